// ----- hw/rtl/ascii_command_frame_parser_macros.svh -----
// Assertion macros for the ASCII command frame parser.
// Included by the top level; depends on nothing else.
`ifndef ASCII_COMMAND_FRAME_PARSER_MACROS_SVH
`define ASCII_COMMAND_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("afp assertion failed");

// Next-cycle implication, checked outside reset
`define AFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("afp assertion failed");

`endif

// ----- hw/rtl/afp_pkg.sv -----
// Shared constants for the ASCII command frame parser.
// No dependencies; imported by the parser top level.
`default_nettype none

package afp_pkg;

    // Longest payload accepted, sign and dot included
    localparam int unsigned MAX_LEN = 16;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned MAG_W   = 54;
    localparam int unsigned MANT_W  = MAG_W + 1;
    localparam int unsigned CNT_W   = 5;
    localparam int unsigned CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_BYTE  = 1'd1;

    // Reset values of the delimiters
    localparam logic [BYTE_W-1:0] START_RESET = 8'h24;  // '$'
    localparam logic [BYTE_W-1:0] STOP_RESET  = 8'h23;  // '#'

    // Payload characters
    localparam logic [BYTE_W-1:0] CHAR_0     = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9     = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT   = 8'h2E;

    typedef logic [BYTE_W-1:0] t_byte;

endpackage

`default_nettype wire

// ----- hw/rtl/ascii_command_frame_parser.sv -----
// ASCII command frame parser: byte register, frame state machine, result register.
// Depends on afp_pkg and ascii_command_frame_parser_macros.svh.
`default_nettype none
`include "ascii_command_frame_parser_macros.svh"

// Takes one received byte per cycle, unless stalled, and recognizes frames
// of the form start, letter, digit, optional sign, digits with at most one
// dot, stop. Throughput is one byte per cycle while not stalled; the only
// limit is the magnitude update (times ten plus digit, a shift-add over 54
// bits) between the byte register and the state registers. A frame result
// reaches the output after its stop byte is accepted: the byte sits in the
// byte register and the word is then loaded into the result register. The
// whole parser halts while a result waits and the receiver stalls; input
// stall is raised only when a byte is held and the result register is full
// and stalled. Malformed frames produce no word.
// The delimiters are written through the configuration port (index 0 start,
// index 1 stop) and must only change while the parser holds no byte.
module ascii_command_frame_parser (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    // received bytes
    input  wire                                    i_rx_valid,
    output logic                                   o_rx_stall,
    input  wire  [afp_pkg::BYTE_W-1:0]             i_rx_byte,
    // frame results
    output logic                                   o_res_valid,
    input  wire                                    i_res_stall,
    output logic [afp_pkg::BYTE_W-1:0]             o_command_letter,
    output logic [afp_pkg::DIGIT_W-1:0]            o_command_digit,
    output logic signed [afp_pkg::MANT_W-1:0]      o_value_mantissa,
    output logic [afp_pkg::CNT_W-1:0]              o_fraction_digits,
    output logic [afp_pkg::CNT_W-1:0]              o_payload_length,
    // configuration writes
    input  wire                                    i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire  [afp_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire  [afp_pkg::BYTE_W-1:0]             i_cfg_data
);
    import afp_pkg::*;

    // Parse phases
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_START   = 2'd1;
    localparam logic [1:0] PH_LETTER  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    // Delimiter registers
    t_byte r_start_byte;
    t_byte r_stop_byte;

    // Byte register
    logic  r_in_valid;
    t_byte r_in_byte;

    // Parse state
    logic [1:0]         r_phase,      n_phase;
    logic               r_sign_seen,  n_sign_seen;
    logic               r_dot_seen,   n_dot_seen;
    logic               r_negative,   n_negative;
    logic [CNT_W-1:0]   r_char_count, n_char_count;
    logic [MAG_W-1:0]   r_magnitude,  n_magnitude;
    logic [CNT_W-1:0]   r_frac_count, n_frac_count;
    t_byte              r_letter,     n_letter;
    logic [DIGIT_W-1:0] r_digit,      n_digit;

    // Result register
    logic                     r_res_valid;
    t_byte                    r_res_letter;
    logic [DIGIT_W-1:0]       r_res_digit;
    logic signed [MANT_W-1:0] r_res_mantissa;
    logic [CNT_W-1:0]         r_res_frac;
    logic [CNT_W-1:0]         r_res_len;

    logic             advance;
    logic             emit;
    logic             is_digit;
    logic             room;
    logic [MAG_W-1:0] mag_times_ten;
    logic [MANT_W-1:0] mant_pos;

    // Pipeline moves whenever the result register can take a word
    assign advance    = !r_res_valid || !i_res_stall;
    assign o_rx_stall = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    assign is_digit = (r_in_byte >= CHAR_0) && (r_in_byte <= CHAR_9);
    assign room     = r_char_count < MAX_CNT;
    // magnitude is below 10^15 whenever a digit is added, so the product fits in MAG_W bits
    assign mag_times_ten = (r_magnitude << 3) + (r_magnitude << 1);
    assign mant_pos      = {1'b0, r_magnitude};

    // Frame state machine, one byte per cycle while the pipeline advances
    always_comb begin
        n_phase      = r_phase;
        n_sign_seen  = r_sign_seen;
        n_dot_seen   = r_dot_seen;
        n_negative   = r_negative;
        n_char_count = r_char_count;
        n_magnitude  = r_magnitude;
        n_frac_count = r_frac_count;
        n_letter     = r_letter;
        n_digit      = r_digit;
        emit         = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                n_sign_seen  = 1'b0;
                n_dot_seen   = 1'b0;
                n_negative   = 1'b0;
                n_char_count = '0;
                n_magnitude  = '0;
                n_frac_count = '0;
                if (r_in_byte == r_start_byte) begin
                    n_phase = PH_START;
                end
            end
            PH_START: begin
                n_sign_seen  = 1'b0;
                n_dot_seen   = 1'b0;
                n_negative   = 1'b0;
                n_char_count = '0;
                n_magnitude  = '0;
                n_frac_count = '0;
                // start wins over stop when both match
                priority if (r_in_byte == r_start_byte) begin
                    n_phase = PH_START;
                end else if (r_in_byte == r_stop_byte) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_letter = r_in_byte;
                    n_phase  = PH_LETTER;
                end
            end
            PH_LETTER: begin
                priority if (r_in_byte == r_start_byte) begin
                    n_phase = PH_START;
                end else if (is_digit) begin
                    // low nibble of an ASCII digit is its value
                    n_digit = r_in_byte[DIGIT_W-1:0];
                    n_phase = PH_PAYLOAD;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PAYLOAD: begin
                // payload meanings are tested before the delimiters
                priority if (r_in_byte == CHAR_PLUS || r_in_byte == CHAR_MINUS) begin
                    if (!r_sign_seen && r_char_count == '0 && room) begin
                        n_sign_seen  = 1'b1;
                        n_negative   = (r_in_byte == CHAR_MINUS);
                        n_char_count = r_char_count + 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (r_in_byte == CHAR_DOT) begin
                    if (!r_dot_seen && room) begin
                        n_dot_seen   = 1'b1;
                        n_char_count = r_char_count + 1'b1;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (is_digit) begin
                    if (room) begin
                        n_char_count = r_char_count + 1'b1;
                        n_magnitude  = mag_times_ten
                                     + MAG_W'(r_in_byte[DIGIT_W-1:0]);
                        if (r_dot_seen) begin
                            n_frac_count = r_frac_count + 1'b1;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                    end
                end else if (r_in_byte == r_start_byte) begin
                    n_phase = PH_START;
                end else if (r_in_byte == r_stop_byte) begin
                    emit    = 1'b1;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // Delimiter registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
            r_stop_byte  <= STOP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_BYTE: r_start_byte <= i_cfg_data;
                CFG_STOP_BYTE:  r_stop_byte  <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Byte register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    // Parse state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_sign_seen  <= 1'b0;
            r_dot_seen   <= 1'b0;
            r_negative   <= 1'b0;
            r_char_count <= '0;
            r_magnitude  <= '0;
            r_frac_count <= '0;
            r_letter     <= '0;
            r_digit      <= '0;
        end else if (r_in_valid && advance) begin
            r_phase      <= n_phase;
            r_sign_seen  <= n_sign_seen;
            r_dot_seen   <= n_dot_seen;
            r_negative   <= n_negative;
            r_char_count <= n_char_count;
            r_magnitude  <= n_magnitude;
            r_frac_count <= n_frac_count;
            r_letter     <= n_letter;
            r_digit      <= n_digit;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (advance) begin
            r_res_valid <= r_in_valid && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid && emit) begin
            r_res_letter   <= r_letter;
            r_res_digit    <= r_digit;
            r_res_mantissa <= r_negative ? -$signed(mant_pos) : $signed(mant_pos);
            r_res_frac     <= r_frac_count;
            r_res_len      <= r_char_count;
        end
    end

    assign o_res_valid       = r_res_valid;
    assign o_command_letter  = r_res_letter;
    assign o_command_digit   = r_res_digit;
    assign o_value_mantissa  = r_res_mantissa;
    assign o_fraction_digits = r_res_frac;
    assign o_payload_length  = r_res_len;

    // Consistency checks
    `AFP_ASSERT_IMP(a_frac_needs_dot, i_clk, i_rst_n, !r_dot_seen, r_frac_count == '0)
    `AFP_ASSERT_IMP(a_frac_within_len, i_clk, i_rst_n, r_res_valid, r_res_frac <= r_res_len)
    `AFP_ASSERT_IMP(a_len_bounded, i_clk, i_rst_n, r_res_valid, r_res_len <= MAX_CNT)
    `AFP_ASSERT_NEXT(a_emit_loads, i_clk, i_rst_n, r_in_valid && advance && emit, r_res_valid)

endmodule

`default_nettype wire

// ----- tb/tb_ascii_command_frame_parser.sv -----
// Self-checking testbench for the ASCII command frame parser.
// Drives received bytes and delimiter writes and checks each result word against a predictor.
// Depends on afp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ascii_command_frame_parser;
    import afp_pkg::*;

    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned PHASE_BYTES     = 215;
    localparam int unsigned N_SETTINGS      = 7;
    localparam int unsigned TIMEOUT_NS      = 1_000_000;

    typedef enum logic [1:0] {SEEK_START, GOT_START, GOT_LETTER, IN_PAYLOAD} t_frame_phase;

    // Frame parse predictor plus the queue of frame words it still expects
    class t_frame_scoreboard;
        t_byte                     start_b;
        t_byte                     stop_b;
        t_frame_phase              phase;
        bit                        sign_seen;
        bit                        dot_seen;
        bit                        negative;
        int unsigned               n_chars;
        int unsigned               n_frac;
        logic [MAG_W-1:0]          magnitude;
        t_byte                     letter;
        logic [DIGIT_W-1:0]        digit;
        t_byte                     exp_letter[$];
        logic [DIGIT_W-1:0]        exp_digit[$];
        logic signed [MANT_W-1:0]  exp_mant[$];
        logic [CNT_W-1:0]          exp_frac[$];
        logic [CNT_W-1:0]          exp_len[$];
        int unsigned               n_errors;

        function new();
            start_b  = START_RESET;
            stop_b   = STOP_RESET;
            phase    = SEEK_START;
            letter   = '0;
            digit    = '0;
            n_errors = 0;
            clear_payload();
        endfunction

        function void clear_payload();
            sign_seen = 0;
            dot_seen  = 0;
            negative  = 0;
            n_chars   = 0;
            n_frac    = 0;
            magnitude = '0;
        endfunction

        function int unsigned pending();
            return exp_letter.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, t_byte data);
            case (idx)
                CFG_START_BYTE: start_b = data;
                CFG_STOP_BYTE:  stop_b = data;
                default: ;
            endcase
        endfunction

        // One accepted byte: advance the frame state, queue a word on a closed frame
        function void note_byte(t_byte b);
            bit is_digit;
            bit room;
            logic [MANT_W-1:0] mant;
            is_digit = (b >= CHAR_0) && (b <= CHAR_9);
            room = n_chars < MAX_LEN;
            case (phase)
                SEEK_START: begin
                    clear_payload();
                    if (b == start_b) phase = GOT_START;
                end
                GOT_START: begin
                    clear_payload();
                    if (b == start_b) begin
                        phase = GOT_START;
                    end else if (b == stop_b) begin
                        phase = SEEK_START;
                    end else begin
                        letter = b;
                        phase = GOT_LETTER;
                    end
                end
                GOT_LETTER: begin
                    if (b == start_b) begin
                        phase = GOT_START;
                    end else if (is_digit) begin
                        digit = DIGIT_W'(b - CHAR_0);
                        phase = IN_PAYLOAD;
                    end else begin
                        phase = SEEK_START;
                    end
                end
                default: begin
                    // sign, dot and digit meanings win over the delimiters
                    if (b == CHAR_PLUS || b == CHAR_MINUS) begin
                        if (!sign_seen && n_chars == 0 && room) begin
                            sign_seen = 1;
                            negative = (b == CHAR_MINUS);
                            n_chars++;
                        end else begin
                            phase = SEEK_START;
                        end
                    end else if (b == CHAR_DOT) begin
                        if (!dot_seen && room) begin
                            dot_seen = 1;
                            n_chars++;
                        end else begin
                            phase = SEEK_START;
                        end
                    end else if (is_digit) begin
                        if (room) begin
                            n_chars++;
                            magnitude = magnitude * 10 + MAG_W'(b - CHAR_0);
                            if (dot_seen) n_frac++;
                        end else begin
                            phase = SEEK_START;
                        end
                    end else if (b == start_b) begin
                        phase = GOT_START;
                    end else if (b == stop_b) begin
                        mant = {1'b0, magnitude};
                        if (negative) mant = -mant;
                        exp_letter.push_back(letter);
                        exp_digit.push_back(digit);
                        exp_mant.push_back(mant);
                        exp_frac.push_back(CNT_W'(n_frac));
                        exp_len.push_back(CNT_W'(n_chars));
                        phase = SEEK_START;
                    end else begin
                        phase = SEEK_START;
                    end
                end
            endcase
        endfunction

        function void mismatch(string field, longint expd, longint got);
            n_errors++;
            $error("%s: expected %0d, got %0d", field, expd, got);
        endfunction

        // One accepted result word against the oldest expectation
        function void check_result(t_byte got_letter, logic [DIGIT_W-1:0] got_digit,
                                   logic signed [MANT_W-1:0] got_mant,
                                   logic [CNT_W-1:0] got_frac, logic [CNT_W-1:0] got_len);
            t_byte                    e_letter;
            logic [DIGIT_W-1:0]       e_digit;
            logic signed [MANT_W-1:0] e_mant;
            logic [CNT_W-1:0]         e_frac;
            logic [CNT_W-1:0]         e_len;
            if (exp_letter.size() == 0) begin
                n_errors++;
                $error("result word with no frame pending: letter %0d digit %0d value %0d",
                       got_letter, got_digit, got_mant);
                return;
            end
            e_letter = exp_letter.pop_front();
            e_digit  = exp_digit.pop_front();
            e_mant   = exp_mant.pop_front();
            e_frac   = exp_frac.pop_front();
            e_len    = exp_len.pop_front();
            if (got_letter !== e_letter) mismatch("command_letter", e_letter, got_letter);
            if (got_digit !== e_digit) mismatch("command_digit", e_digit, got_digit);
            if (got_mant !== e_mant) mismatch("value_mantissa", e_mant, got_mant);
            if (got_frac !== e_frac) mismatch("fraction_digits", e_frac, got_frac);
            if (got_len !== e_len) mismatch("payload_length", e_len, got_len);
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_rx_valid;
    logic                      o_rx_stall;
    logic [BYTE_W-1:0]         i_rx_byte;
    logic                      o_res_valid;
    logic                      i_res_stall;
    logic [BYTE_W-1:0]         o_command_letter;
    logic [DIGIT_W-1:0]        o_command_digit;
    logic signed [MANT_W-1:0]  o_value_mantissa;
    logic [CNT_W-1:0]          o_fraction_digits;
    logic [CNT_W-1:0]          o_payload_length;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [BYTE_W-1:0]         i_cfg_data;

    t_frame_scoreboard sb = new();

    t_byte       cur_start = START_RESET;
    t_byte       cur_stop = STOP_RESET;
    int unsigned bytes_sent = 0;
    int unsigned burst_left = 0;
    bit          hold_off_req = 0;

    // Delimiter settings per random phase; the fifth slot is drawn at run time
    t_byte start_set [N_SETTINGS] = '{8'h00, 8'hFF, CHAR_PLUS, 8'h41, 8'h00, CHAR_DOT,
                                      START_RESET};
    t_byte stop_set  [N_SETTINGS] = '{8'hFF, 8'h00, CHAR_0, 8'h41, 8'h00, CHAR_MINUS,
                                      STOP_RESET};

    // Short directed sequence at the reset delimiters
    t_byte directed_bytes [28] = '{
        START_RESET, "A", "1", CHAR_MINUS, "1", CHAR_DOT, "5", STOP_RESET,  // full frame
        START_RESET, START_RESET, STOP_RESET,                               // restart, then stop
        START_RESET, 8'hFF, CHAR_9, STOP_RESET,                             // empty payload
        START_RESET, 8'h00, CHAR_0, CHAR_DOT, STOP_RESET,                   // dot only
        START_RESET, "B", "5", CHAR_PLUS, CHAR_PLUS,                        // repeated sign
        START_RESET, "C", "x"                                               // no digit after letter
    };

    ascii_command_frame_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (i_rx_valid),
        .o_rx_stall        (o_rx_stall),
        .i_rx_byte         (i_rx_byte),
        .o_res_valid       (o_res_valid),
        .i_res_stall       (i_res_stall),
        .o_command_letter  (o_command_letter),
        .o_command_digit   (o_command_digit),
        .o_value_mantissa  (o_value_mantissa),
        .o_fraction_digits (o_fraction_digits),
        .o_payload_length  (o_payload_length),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Monitor: sample handshakes at each edge, before any new drive takes effect
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_rx_valid && !o_rx_stall) sb.note_byte(i_rx_byte);
            if (o_res_valid && !i_res_stall)
                sb.check_result(o_command_letter, o_command_digit, o_value_mantissa,
                                o_fraction_digits, o_payload_length);
        end
    end

    // Receiver stall: one long hold-off once asked, otherwise random chunks
    initial begin : res_stall_pattern
        int unsigned mode;
        int unsigned span;
        int unsigned k;
        bit held_off;
        held_off = 0;
        forever begin
            if (hold_off_req && !held_off) begin
                held_off = 1;
                for (k = 0; k < HOLD_OFF_CYCLES; k++) begin
                    i_res_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end else begin
                mode = $urandom_range(0, 3);
                span = (mode == 3) ? $urandom_range(1, 6) : $urandom_range(1, 40);
                for (k = 0; k < span; k++) begin
                    case (mode)
                        0: i_res_stall <= 1'b0;
                        1: i_res_stall <= 1'($urandom_range(0, 1));
                        2: i_res_stall <= ($urandom_range(0, 3) == 0);
                        default: i_res_stall <= 1'b1;
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // Offer one byte and wait until it is taken; bursts with random gaps between them
    task automatic send_byte(input t_byte b);
        int unsigned g;
        int unsigned gap;
        if (burst_left == 0) begin
            g = $urandom_range(0, 9);
            if (g < 4) gap = 0;
            else if (g < 8) gap = $urandom_range(1, 3);
            else gap = $urandom_range(4, 20);
            if (gap != 0) begin
                i_rx_valid <= 1'b0;
                i_rx_byte <= t_byte'($urandom_range(0, 255));
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        burst_left--;
        i_rx_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_rx_stall);
        bytes_sent++;
    endtask

    // Stop offering, let every expected word arrive, then let the byte register empty
    task automatic settle();
        i_rx_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both delimiters back to back; valid stays high between the two words
    task automatic set_delimiters(input t_byte start_v, input t_byte stop_v);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_data <= start_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_STOP_BYTE;
        i_cfg_data <= stop_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_start = start_v;
        cur_stop = stop_v;
    endtask

    // One random frame: mostly well formed, some corrupted or cut short, some noise
    task automatic send_frame();
        t_byte fq[$];
        int unsigned kind;
        int unsigned pick;
        int unsigned plen;
        int unsigned rest;
        int unsigned dot_at;
        int unsigned pos;
        int unsigned i;
        bit nines;
        kind = $urandom_range(0, 99);
        if (kind >= 92) begin
            repeat ($urandom_range(1, 8)) fq.push_back(t_byte'($urandom_range(0, 255)));
        end else begin
            fq.push_back(cur_start);
            fq.push_back(t_byte'($urandom_range(0, 255)));
            fq.push_back(CHAR_0 + t_byte'($urandom_range(0, 9)));
            pick = $urandom_range(0, 99);
            if (pick < 15) plen = MAX_LEN;
            else if (pick < 20) plen = MAX_LEN + 1;
            else if (pick < 30) plen = 0;
            else plen = $urandom_range(1, 12);
            rest = plen;
            if (plen > 0 && $urandom_range(0, 9) < 4) begin
                fq.push_back($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
                rest--;
            end
            // dot_at == rest means no dot
            dot_at = ($urandom_range(0, 9) < 6 && rest > 0) ? $urandom_range(0, rest - 1) : rest;
            nines = ($urandom_range(0, 9) == 0);
            for (i = 0; i < rest; i++) begin
                if (i == dot_at) fq.push_back(CHAR_DOT);
                else if (nines) fq.push_back(CHAR_9);
                else fq.push_back(CHAR_0 + t_byte'($urandom_range(0, 9)));
            end
            fq.push_back(cur_stop);
            pos = $urandom_range(1, fq.size() - 1);
            if (kind >= 70 && kind < 82) begin
                case ($urandom_range(0, 5))
                    0: fq[pos] = CHAR_PLUS;
                    1: fq[pos] = CHAR_MINUS;
                    2: fq[pos] = CHAR_DOT;
                    3: fq[pos] = cur_start;
                    4: fq[pos] = cur_stop;
                    default: fq[pos] = t_byte'($urandom_range(0, 255));
                endcase
            end else if (kind >= 82) begin
                fq = fq[0:pos-1];
            end
        end
        foreach (fq[i]) send_byte(fq[i]);
    endtask

    initial begin : stimulus
        int unsigned p;
        int unsigned phase_end;
        i_rst_n <= 1'b0;
        i_rx_valid <= 1'b0;
        i_rx_byte <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_START_BYTE;
        i_cfg_data <= '0;
        start_set[4] = t_byte'($urandom_range(0, 255));
        stop_set[4] = t_byte'($urandom_range(0, 255));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

        // Random frames under several delimiter settings; the long hold-off lands in the first
        for (p = 0; p < N_SETTINGS; p++) begin
            settle();
            set_delimiters(start_set[p], stop_set[p]);
            if (p == 0) hold_off_req = 1;
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_frame();
        end

        settle();
        if (sb.n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

endmodule

// ----- ascii_command_frame_parser.f -----
+incdir+hw/rtl
hw/rtl/afp_pkg.sv
hw/rtl/ascii_command_frame_parser.sv
tb/tb_ascii_command_frame_parser.sv
